>>> hdl/mlst_pkg.sv
package mlst_pkg;

    // Store geometry.
    localparam int NUM_SLOTS  = 10;
    localparam int MAX_SIZE   = 16;
    localparam int DATA_W     = 32;
    localparam int SLOT_IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W      = $clog2(MAX_SIZE + 1);
    localparam int STORE_D    = NUM_SLOTS * MAX_SIZE;
    localparam int ADDR_W     = (STORE_D > 1) ? $clog2(STORE_D) : 1;

    // Operation codes.
    typedef enum logic [2:0] {
        OP_CREATE = 3'd0,
        OP_APPEND = 3'd1,
        OP_REM_LAST = 3'd2,
        OP_REM_VAL = 3'd3,
        OP_READ = 3'd4
    } t_op;

    // Result status codes.
    typedef enum logic [3:0] {
        STS_OK = 4'd0,
        STS_BAD_SLOT = 4'd1,
        STS_BAD_SIZE = 4'd2,
        STS_EXISTS = 4'd3,
        STS_NO_MEMORY = 4'd4,
        STS_FULL = 4'd5,
        STS_NO_LIST = 4'd6,
        STS_EMPTY = 4'd7,
        STS_NOT_FOUND = 4'd8
    } t_status;

    // What an accepted request turns into after its checks.
    typedef enum logic [1:0] {
        CL_NONE,
        CL_SINGLE,
        CL_SEARCH,
        CL_READ
    } t_class;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_SEARCH,
        S_SHIFT,
        S_READ
    } t_state;

    typedef struct packed {
        logic [2:0]               op;
        logic [3:0]               slot;
        logic [7:0]               size;
        logic signed [DATA_W-1:0] value;
    } t_item;

    typedef struct packed {
        logic [3:0]               status;
        logic signed [DATA_W-1:0] data_out;
        logic                     has_data;
        logic                     last;
    } t_result;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    latch;
        logic    commit;
        logic    init_scan;
        logic    init_shift;
        logic    scan;
        logic    cmp;
        logic    shift;
        logic    emit_elem;
        logic    emit_single;
        t_status emit_code;
        logic    finish_del;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_class  cls;
        t_status eval_code;
        logic    scan_done;
        logic    found;
    } t_stat;

endpackage

>>> hdl/mlst_ram.sv
module mlst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 160
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> hdl/mlst_ctrl.sv
module mlst_ctrl import mlst_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output logic  o_busy,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_EVAL;
            end
            S_EVAL: begin
                unique case (i_stat.cls)
                    CL_SEARCH: n_state = S_SEARCH;
                    CL_READ:   n_state = S_READ;
                    default:   n_state = S_IDLE;
                endcase
            end
            S_SEARCH: begin
                if (i_stat.scan_done) n_state = i_stat.found ? S_SHIFT : S_IDLE;
            end
            S_SHIFT: begin
                if (i_stat.scan_done) n_state = S_IDLE;
            end
            S_READ: begin
                if (i_stat.scan_done) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd           = '0;
        o_cmd.emit_code = STS_OK;
        o_busy          = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                o_cmd.latch = i_start;
            end
            S_EVAL: begin
                unique case (i_stat.cls)
                    CL_SINGLE: begin
                        o_cmd.commit      = 1'b1;
                        o_cmd.emit_single = 1'b1;
                        o_cmd.emit_code   = i_stat.eval_code;
                    end
                    CL_SEARCH, CL_READ: begin
                        o_cmd.init_scan = 1'b1;
                    end
                    default: ;
                endcase
            end
            S_SEARCH: begin
                if (i_stat.scan_done) begin
                    if (i_stat.found) begin
                        o_cmd.init_shift = 1'b1;
                    end else begin
                        o_cmd.emit_single = 1'b1;
                        o_cmd.emit_code   = STS_NOT_FOUND;
                    end
                end else begin
                    o_cmd.scan = 1'b1;
                    o_cmd.cmp  = 1'b1;
                end
            end
            S_SHIFT: begin
                if (i_stat.scan_done) begin
                    o_cmd.emit_single = 1'b1;
                    o_cmd.emit_code   = STS_OK;
                    o_cmd.finish_del  = 1'b1;
                end else begin
                    o_cmd.scan  = 1'b1;
                    o_cmd.shift = 1'b1;
                end
            end
            S_READ: begin
                if (!i_stat.scan_done) begin
                    o_cmd.scan      = 1'b1;
                    o_cmd.emit_elem = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // The checks are only ever made on a freshly latched request.
    a_eval_after_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |-> ($past(r_state) == S_IDLE))
        else $error("check state not entered from idle");

    // The shift runs only after a search that found the value.
    a_shift_after_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) && ($past(r_state) != S_SHIFT) |-> $past(i_stat.found))
        else $error("shift started without a match");

endmodule

>>> hdl/mlst_dp.sv
module mlst_dp import mlst_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_item   i_item,
    input  t_cmd    i_cmd,
    output t_stat   o_stat,
    output logic    o_valid,
    output t_result o_result
);

    // Latched request and per-slot bookkeeping.
    t_item            r_item;
    logic             r_exists [NUM_SLOTS];
    logic [CNT_W-1:0] r_cap    [NUM_SLOTS];
    logic [CNT_W-1:0] r_count  [NUM_SLOTS];

    // Scan engine over one slot's entries.
    logic [ADDR_W-1:0] r_base;
    logic [CNT_W-1:0]  r_idx;
    logic              r_pend;
    logic [CNT_W-1:0]  r_pend_idx;
    logic              r_found;
    logic [CNT_W-1:0]  r_at;

    logic                  r_valid;
    t_result               r_result;

    logic [3:0]            slot_m1;
    logic [SLOT_IDX_W-1:0] s_idx;
    logic                  slot_ok;
    logic                  cur_exists;
    logic [CNT_W-1:0]      cur_cnt;
    logic [CNT_W-1:0]      cur_cap;
    logic [ADDR_W-1:0]     base_c;
    logic                  do_append;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    // Slot lookup for the latched request.
    always_comb begin
        slot_m1    = r_item.slot - 4'd1;
        s_idx      = slot_m1[SLOT_IDX_W-1:0];
        slot_ok    = (r_item.slot != 4'd0) && (r_item.slot <= 4'(NUM_SLOTS));
        cur_exists = slot_ok ? r_exists[s_idx] : 1'b0;
        cur_cnt    = slot_ok ? r_count[s_idx] : '0;
        cur_cap    = slot_ok ? r_cap[s_idx] : '0;
        base_c     = ADDR_W'(s_idx * MAX_SIZE);
    end

    // Request checks, in the order the operations define.
    always_comb begin
        o_stat.cls       = CL_SINGLE;
        o_stat.eval_code = STS_OK;
        if (r_item.op > OP_READ) begin
            o_stat.cls = CL_NONE;
        end else if (!slot_ok) begin
            o_stat.eval_code = STS_BAD_SLOT;
        end else if (r_item.op == OP_CREATE) begin
            if (r_item.size == 8'd0) begin
                o_stat.eval_code = STS_BAD_SIZE;
            end else if (cur_exists) begin
                o_stat.eval_code = STS_EXISTS;
            end else if (r_item.size > 8'(MAX_SIZE)) begin
                o_stat.eval_code = STS_NO_MEMORY;
            end
        end else if (!cur_exists) begin
            o_stat.eval_code = STS_NO_LIST;
        end else begin
            unique case (r_item.op)
                OP_APPEND: begin
                    if (cur_cnt >= cur_cap || cur_cnt >= CNT_W'(MAX_SIZE)) begin
                        o_stat.eval_code = STS_FULL;
                    end
                end
                OP_REM_LAST: begin
                    if (cur_cnt == '0) o_stat.eval_code = STS_EMPTY;
                end
                OP_REM_VAL: begin
                    if (cur_cnt == '0) o_stat.eval_code = STS_EMPTY;
                    else o_stat.cls = CL_SEARCH;
                end
                OP_READ: begin
                    if (cur_cnt != '0) o_stat.cls = CL_READ;
                end
                default: o_stat.cls = CL_NONE;
            endcase
        end
        o_stat.scan_done = (r_idx >= cur_cnt) && !r_pend;
        o_stat.found     = r_found;
    end

    assign do_append = i_cmd.commit && (o_stat.eval_code == STS_OK)
                       && (r_item.op == OP_APPEND);

    // Request latch.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item <= i_item;
        end
    end

    // Slot table updates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_SLOTS; k++) begin
                r_exists[k] <= 1'b0;
                r_cap[k]    <= '0;
                r_count[k]  <= '0;
            end
        end else if (i_cmd.commit && o_stat.eval_code == STS_OK) begin
            case (r_item.op)
                OP_CREATE: begin
                    r_exists[s_idx] <= 1'b1;
                    r_cap[s_idx]    <= r_item.size[CNT_W-1:0];
                    r_count[s_idx]  <= '0;
                end
                OP_APPEND:   r_count[s_idx] <= cur_cnt + CNT_W'(1);
                OP_REM_LAST: r_count[s_idx] <= cur_cnt - CNT_W'(1);
                default: ;
            endcase
        end else if (i_cmd.finish_del) begin
            r_count[s_idx] <= cur_cnt - CNT_W'(1);
        end
    end

    // Scan engine: one read issued per cycle, its data checked in the next cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_pend  <= 1'b0;
            r_found <= 1'b0;
        end else if (i_cmd.init_scan) begin
            r_idx   <= '0;
            r_pend  <= 1'b0;
            r_found <= 1'b0;
            r_base  <= base_c;
        end else if (i_cmd.init_shift) begin
            r_idx  <= r_at + CNT_W'(1);
            r_pend <= 1'b0;
        end else if (i_cmd.scan) begin
            if (r_idx < cur_cnt) begin
                r_idx      <= r_idx + CNT_W'(1);
                r_pend     <= 1'b1;
                r_pend_idx <= r_idx;
            end else begin
                r_pend <= 1'b0;
            end
            if (i_cmd.cmp && r_pend && (ram_rdata == r_item.value)) begin
                r_found <= 1'b1;
                r_at    <= r_pend_idx;
            end
        end
    end

    // Store port selection: append writes the new tail, the shift moves one entry down.
    always_comb begin
        ram_raddr = r_base + ADDR_W'(r_idx);
        ram_we    = do_append || (i_cmd.shift && r_pend);
        if (i_cmd.shift) begin
            ram_waddr = r_base + ADDR_W'(r_pend_idx - CNT_W'(1));
            ram_wdata = ram_rdata;
        end else begin
            ram_waddr = base_c + ADDR_W'(cur_cnt);
            ram_wdata = r_item.value;
        end
    end

    mlst_ram #(
        .WIDTH(DATA_W),
        .DEPTH(STORE_D)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // Result register: each transfer is shown for one cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (i_cmd.emit_single) begin
                r_valid           <= 1'b1;
                r_result.status   <= i_cmd.emit_code;
                r_result.data_out <= '0;
                r_result.has_data <= 1'b0;
                r_result.last     <= 1'b1;
            end else if (i_cmd.emit_elem && r_pend) begin
                r_valid           <= 1'b1;
                r_result.status   <= STS_OK;
                r_result.data_out <= ram_rdata;
                r_result.has_data <= 1'b1;
                r_result.last     <= (r_pend_idx == cur_cnt - CNT_W'(1));
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    // A pending read always refers to a filled entry of the slot.
    a_pend_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_pend_idx < cur_cnt))
        else $error("pending read beyond slot fill");

    // The shift never writes the entry it is reading in the same cycle.
    a_shift_no_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.shift && r_pend) |-> (ram_waddr != ram_raddr))
        else $error("shift write collides with read");

endmodule

>>> hdl/multi_list_store_with_delete_shift.sv
// Multi-list store with delete-shift.
// A request (op, slot, size, value) is transferred on a rising edge where
// start is high and busy is low. busy stays high until the request is done.
// Results come out on o_result, each for exactly one cycle with o_valid high;
// the receiver cannot stall, so every result must be taken when shown.
// Create, append, remove last and every request that fails its checks give
// one result from the check state; busy is high in that state only.
// Read list gives one result per element on consecutive cycles, the final
// one marked by last; an empty list gives one result without data.
// Remove value scans the slot's entries one per cycle through the element
// memory, then moves the later entries down one per cycle through the same
// memory; both passes are paced by its one read port and one write port.
// Undefined operations give no result and free the block after the checks.
// Reset clears all slots to not created; the element memory needs no clearing
// since only entries below a slot's fill count are ever read.
module multi_list_store_with_delete_shift import mlst_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_item   i_item,
    output logic    busy,
    output logic    o_valid,
    output t_result o_result
);

    t_cmd  cmd;
    t_stat stat;

    mlst_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_stat (stat),
        .o_busy (busy),
        .o_cmd  (cmd)
    );

    mlst_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    // A read-out stream runs without gaps until its final element.
    a_stream_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.last) |=> (o_valid && o_result.has_data))
        else $error("read-out stream broke before its last element");

endmodule

>>> tb/multi_list_store_with_delete_shift_tb.sv
`timescale 1ns / 1ps

module multi_list_store_with_delete_shift_tb;
    import mlst_pkg::*;

    // Opcodes that the block must ignore.
    localparam logic [2:0] OP_RSVD_A = 3'd5;
    localparam logic [2:0] OP_RSVD_B = 3'd6;
    localparam logic [2:0] OP_RSVD_C = 3'd7;

    // Cycles without any transfer before the run is declared hung.
    localparam int STALL_LIMIT = 2000;
    localparam int ITEMS_PER_PHASE = 70;

    // Predicts the results of every accepted request and checks the block's output.
    class list_scoreboard;
        bit                created [NUM_SLOTS];
        int                capacity [NUM_SLOTS];
        int                fill [NUM_SLOTS];
        logic [DATA_W-1:0] elems [NUM_SLOTS][MAX_SIZE];
        t_result           pending_results [$];
        int                errors;

        function void push_result(t_status code, logic [DATA_W-1:0] data, bit has, bit fin);
            t_result r;
            r.status   = code;
            r.data_out = data;
            r.has_data = has;
            r.last     = fin;
            pending_results.push_back(r);
        endfunction

        // Update the list state for one accepted request and queue its results.
        function void note_request(t_item req);
            int s;
            int pos;
            bit hit;
            if (req.op > OP_READ) begin
                return;
            end
            if (req.slot < 1 || req.slot > NUM_SLOTS) begin
                push_result(STS_BAD_SLOT, '0, 1'b0, 1'b1);
                return;
            end
            s = req.slot - 1;
            if (req.op == OP_CREATE) begin
                if (req.size < 1) begin
                    push_result(STS_BAD_SIZE, '0, 1'b0, 1'b1);
                end else if (created[s]) begin
                    push_result(STS_EXISTS, '0, 1'b0, 1'b1);
                end else if (req.size > MAX_SIZE) begin
                    push_result(STS_NO_MEMORY, '0, 1'b0, 1'b1);
                end else begin
                    created[s]  = 1'b1;
                    capacity[s] = req.size;
                    fill[s]     = 0;
                    push_result(STS_OK, '0, 1'b0, 1'b1);
                end
                return;
            end
            if (!created[s]) begin
                push_result(STS_NO_LIST, '0, 1'b0, 1'b1);
                return;
            end
            case (req.op)
                OP_APPEND: begin
                    if (fill[s] >= capacity[s]) begin
                        push_result(STS_FULL, '0, 1'b0, 1'b1);
                    end else begin
                        elems[s][fill[s]] = req.value;
                        fill[s]++;
                        push_result(STS_OK, '0, 1'b0, 1'b1);
                    end
                end
                OP_REM_LAST: begin
                    if (fill[s] == 0) begin
                        push_result(STS_EMPTY, '0, 1'b0, 1'b1);
                    end else begin
                        fill[s]--;
                        push_result(STS_OK, '0, 1'b0, 1'b1);
                    end
                end
                OP_REM_VAL: begin
                    hit = 1'b0;
                    pos = 0;
                    if (fill[s] == 0) begin
                        push_result(STS_EMPTY, '0, 1'b0, 1'b1);
                        return;
                    end
                    // The last occurrence among the filled entries is removed.
                    for (int i = 0; i < fill[s]; i++) begin
                        if (elems[s][i] == req.value) begin
                            hit = 1'b1;
                            pos = i;
                        end
                    end
                    if (!hit) begin
                        push_result(STS_NOT_FOUND, '0, 1'b0, 1'b1);
                        return;
                    end
                    for (int i = pos; i + 1 < fill[s]; i++) begin
                        elems[s][i] = elems[s][i + 1];
                    end
                    fill[s]--;
                    push_result(STS_OK, '0, 1'b0, 1'b1);
                end
                default: begin
                    // Read out: an empty list still gives one marker result.
                    if (fill[s] == 0) begin
                        push_result(STS_OK, '0, 1'b0, 1'b1);
                    end else begin
                        for (int i = 0; i < fill[s]; i++) begin
                            push_result(STS_OK, elems[s][i], 1'b1, (i + 1 == fill[s]));
                        end
                    end
                end
            endcase
        endfunction

        // Compare one result transfer with the oldest outstanding prediction.
        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, status %0d data %0d has_data %0b last %0b",
                         $time, got.status, got.data_out, got.has_data, got.last);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, want.status, got.status);
                errors++;
            end
            if (got.data_out !== want.data_out) begin
                $display("%0t: data_out mismatch, expected %0d, actual %0d",
                         $time, want.data_out, got.data_out);
                errors++;
            end
            if (got.has_data !== want.has_data) begin
                $display("%0t: has_data mismatch, expected %0b, actual %0b",
                         $time, want.has_data, got.has_data);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last mismatch, expected %0b, actual %0b",
                         $time, want.last, got.last);
                errors++;
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    t_item   i_item;
    logic    busy;
    logic    o_valid;
    t_result o_result;

    list_scoreboard sb;
    bit             no_gaps;
    int             idle_cycles;

    multi_list_store_with_delete_shift DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Every result is taken on the edge that ends its cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            sb.check_result(o_result);
        end
    end

    // Watchdog: ends the run after a long stretch with no transfer at all.
    always @(posedge i_clk) begin
        if (!i_rst_n || o_valid || (start && !busy)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Mostly back to back or short pauses, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // A small pool of values makes duplicates in a list likely.
    function automatic logic [31:0] pool_value();
        case ($urandom_range(0, 5))
            0: return 32'h0000_0000;
            1: return 32'h0000_0001;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0007;
            4: return 32'h8000_0000;
            default: return 32'h7FFF_FFFF;
        endcase
    endfunction

    // Present one request and hold it until the block takes it.
    task automatic send_req(input logic [2:0] op, input int slot, input int size,
                            input logic [31:0] value);
        t_item req;
        int    gap;
        req.op    = op;
        req.slot  = slot[3:0];
        req.size  = size[7:0];
        req.value = value;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= req;
        do @(posedge i_clk); while (busy);
        sb.note_request(req);
    endtask

    // Stop sending and wait until every predicted result has come back.
    task automatic drain();
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // One random request, biased toward valid slots and values already stored.
    task automatic random_request(output bit counted);
        int          r;
        int          slot;
        int          size;
        int          s;
        logic [2:0]  op;
        logic [31:0] value;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            op = OP_CREATE;
        end else if (r < 45) begin
            op = OP_APPEND;
        end else if (r < 55) begin
            op = OP_REM_LAST;
        end else if (r < 75) begin
            op = OP_REM_VAL;
        end else if (r < 95) begin
            op = OP_READ;
        end else begin
            case ($urandom_range(0, 2))
                0: op = OP_RSVD_A;
                1: op = OP_RSVD_B;
                default: op = OP_RSVD_C;
            endcase
        end
        if ($urandom_range(0, 19) == 0) begin
            slot = $urandom_range(0, 1) ? 0 : $urandom_range(NUM_SLOTS + 1, 15);
        end else begin
            slot = $urandom_range(1, NUM_SLOTS);
        end
        case ($urandom_range(0, 9))
            0: size = 0;
            1: size = $urandom_range(MAX_SIZE + 1, 255);
            default: size = $urandom_range(1, MAX_SIZE);
        endcase
        value = ($urandom_range(0, 9) < 4) ? pool_value() : $urandom;
        // Removal mostly targets a value that is in the list.
        if (op == OP_REM_VAL && slot >= 1 && slot <= NUM_SLOTS) begin
            s = slot - 1;
            if (sb.fill[s] > 0 && $urandom_range(0, 9) < 7) begin
                value = sb.elems[s][$urandom_range(0, sb.fill[s] - 1)];
            end
        end
        counted = (op <= OP_READ);
        send_req(op, slot, size, value);
    endtask

    initial begin
        int done;
        bit counted;
        sb = new();
        no_gaps = 1'b0;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_item  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Rejections on bad slots and on slots never created.
        send_req(OP_READ, 0, 0, 32'h0);
        send_req(OP_CREATE, 15, 4, 32'h0);
        send_req(OP_APPEND, NUM_SLOTS + 1, 1, 32'h5);
        send_req(OP_APPEND, 1, 1, 32'h5);
        send_req(OP_REM_LAST, 1, 1, 32'h0);
        send_req(OP_REM_VAL, 1, 1, 32'h5);
        send_req(OP_READ, 1, 1, 32'h0);
        // Create checks in their order of precedence.
        send_req(OP_CREATE, 1, 0, 32'h0);
        send_req(OP_CREATE, 1, MAX_SIZE + 1, 32'h0);
        send_req(OP_CREATE, 1, 255, 32'h0);
        send_req(OP_CREATE, 1, 3, 32'h0);
        send_req(OP_CREATE, 1, 0, 32'h0);
        send_req(OP_CREATE, 1, 8, 32'h0);
        // Empty list handling.
        send_req(OP_READ, 1, 0, 32'h0);
        send_req(OP_REM_LAST, 1, 0, 32'h0);
        send_req(OP_REM_VAL, 1, 0, 32'h0);
        // Fill to capacity with extreme values, then overflow.
        send_req(OP_APPEND, 1, 0, 32'h7FFF_FFFF);
        send_req(OP_APPEND, 1, 0, 32'h8000_0000);
        send_req(OP_APPEND, 1, 0, 32'hFFFF_FFFF);
        send_req(OP_APPEND, 1, 0, 32'h0);
        // Removal of an absent value and of a middle entry.
        send_req(OP_REM_VAL, 1, 0, 32'h5);
        send_req(OP_REM_VAL, 1, 0, 32'h8000_0000);
        send_req(OP_READ, 1, 0, 32'h0);
        send_req(OP_CREATE, NUM_SLOTS, MAX_SIZE, 32'h0);
        // Undefined opcodes are dropped without a result.
        send_req(OP_RSVD_A, 1, 0, 32'h0);
        send_req(OP_RSVD_B, 1, 0, 32'h0);
        send_req(OP_RSVD_C, 1, 0, 32'h0);
        send_req(OP_REM_LAST, 1, 0, 32'h0);
        drain();

        // Random phases; one runs without any idle cycles.
        for (int phase = 0; phase < 4; phase++) begin
            no_gaps = (phase == 1);
            done = 0;
            while (done < ITEMS_PER_PHASE) begin
                random_request(counted);
                if (counted) begin
                    done++;
                end
            end
            drain();
        end

        repeat (40) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
